>>> rtl/core/aes_sbw_pkg.sv
package aes_sbw_pkg;

  // Item geometry: one state column of four bytes
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NBytes = 4;
  localparam int unsigned WordW  = ByteW * NBytes;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [WordW-1:0] word_t;

  // S-box value of a zero byte (inverse of zero taken as zero)
  localparam byte_t SboxZero = 8'h63;

  // Forward S-box: GF(2^8) inverse mod 0x11b, then affine map
  // (rows 0xf8 rotated right per row) XOR 0x63. Index 0 first.
  localparam byte_t SboxTbl [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage

>>> rtl/core/aes_sbw_lane.sv
// One byte lane: forward S-box lookup
module aes_sbw_lane (
  input  aes_sbw_pkg::byte_t in_byte_i,
  output aes_sbw_pkg::byte_t sub_byte_o
);

  assign sub_byte_o = aes_sbw_pkg::SboxTbl[in_byte_i];

endmodule

>>> rtl/core/aes_sub_bytes_word_unit.sv
// Channel  | Ports                            | Handshake
// ---------+----------------------------------+-----------------------------
// item in  | start, busy, column_word_i       | taken when start && !busy
// item out | done_o, substituted_word_o       | one-cycle strobe on done_o
//
// One item per cycle, sustained; busy stays low.
// Path: input register, four table lookups, result register.
// The S-box lookup per byte lane sets the path between the two registers.
// Reset (rst_ni low, async) clears the valid bits; data registers are not reset.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module aes_sub_bytes_word_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  aes_sbw_pkg::word_t  column_word_i,
  output logic                done_o,
  output aes_sbw_pkg::word_t  substituted_word_o
);

  logic               in_vld_q;
  aes_sbw_pkg::word_t in_word_q;
  logic               res_vld_q;
  aes_sbw_pkg::word_t res_word_q;
  aes_sbw_pkg::word_t res_word_d;
  logic               accept;

  // never holds off: a new item every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= column_word_i;
    end
  end

  // four byte lanes, same byte order out as in
  for (genvar b = 0; b < aes_sbw_pkg::NBytes; b++) begin : g_lane
    aes_sbw_lane u_lane (
      .in_byte_i  (in_word_q[b*aes_sbw_pkg::ByteW +: aes_sbw_pkg::ByteW]),
      .sub_byte_o (res_word_d[b*aes_sbw_pkg::ByteW +: aes_sbw_pkg::ByteW])
    );
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_word_q <= res_word_d;
    end
  end

  assign done_o             = res_vld_q;
  assign substituted_word_o = res_word_q;

`ifndef SYNTHESIS
  // every accepted item raises done_o once it has passed the input and result registers
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted item did not produce a result");

  // no result without an item accepted ahead of it through both registers
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result strobe without an accepted item");

  // an all-zero column maps to the zero-byte S-box value in every lane
  a_zero_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && (in_word_q == '0)) |=>
      (substituted_word_o == {aes_sbw_pkg::NBytes{aes_sbw_pkg::SboxZero}}))
    else $error("zero column not mapped to 0x63 bytes");

  // result data only changes when a new item completes (still unset after reset)
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_vld_q) |-> (res_word_q === $past(res_word_q)))
    else $error("result register changed without an item");
`endif

endmodule

>>> tb/tb_top.sv
module tb_top;
  import aes_sbw_pkg::*;

  // GF(2^8) field polynomial and affine transform constants
  localparam logic [ByteW:0] FieldPoly    = 9'h11b;
  localparam byte_t          AffineRow0   = 8'hf8;
  localparam byte_t          AffineOffset = 8'h63;

  localparam int unsigned ShowLimit   = 10;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned TailCycles  = 4;

  // Corner columns: extremes, a zero byte in each lane, byte patterns
  localparam word_t CornerColumns [20] = '{
    32'h00000000, 32'hffffffff, 32'h00000001, 32'h80000000,
    32'h01010101, 32'h80808080, 32'h7f7f7f7f, 32'hfefefefe,
    32'h00c1d2e3, 32'hc100d2e3, 32'hc1d200e3, 32'hc1d2e300,
    32'h63636363, 32'h52525252, 32'h01020408, 32'h10204080,
    32'h55aa55aa, 32'haa55aa55, 32'h53ca0f1e, 32'h12345678
  };

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  start       = 1'b0;
  word_t column_word = '0;
  logic  busy;
  logic  done;
  word_t substituted_word;

  word_t       expected_columns [$];
  int unsigned fail_count = 0;

  aes_sub_bytes_word_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .column_word_i      (column_word),
    .done_o             (done),
    .substituted_word_o (substituted_word)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Carry-less multiply, reduced modulo the field polynomial
  function automatic byte_t gf_times(byte_t a, byte_t b);
    logic [ByteW:0] x;
    byte_t          acc;
    x   = {1'b0, a};
    acc = '0;
    for (int k = 0; k < ByteW; k++) begin
      if (b[k]) acc ^= x[ByteW-1:0];
      x = x << 1;
      if (x[ByteW]) x ^= FieldPoly;
    end
    return acc;
  endfunction

  // a^254 is the inverse of a; zero stays zero
  function automatic byte_t gf_reciprocal(byte_t a);
    byte_t       acc;
    byte_t       base;
    int unsigned e;
    acc  = 8'h01;
    base = a;
    e    = 254;
    while (e != 0) begin
      if (e[0]) acc = gf_times(acc, base);
      base = gf_times(base, base);
      e >>= 1;
    end
    return acc;
  endfunction

  // Inverse, then affine map: row i is the base row rotated right by i, gives bit 7-i
  function automatic byte_t sbox_of(byte_t b);
    byte_t              inv;
    byte_t              row;
    byte_t              res;
    logic [2*ByteW-1:0] twice;
    inv = gf_reciprocal(b);
    res = '0;
    for (int i = 0; i < ByteW; i++) begin
      twice = {AffineRow0, AffineRow0} >> i;
      row   = twice[ByteW-1:0];
      res[ByteW-1-i] = ^(inv & row);
    end
    return res ^ AffineOffset;
  endfunction

  function automatic word_t substitute_column(word_t w);
    word_t r;
    for (int n = 0; n < NBytes; n++) begin
      r[n*ByteW +: ByteW] = sbox_of(w[n*ByteW +: ByteW]);
    end
    return r;
  endfunction

  task automatic flag_failure(string msg);
    fail_count++;
    if (fail_count <= ShowLimit) $display("%0t: %s", $time, msg);
  endtask

  // Result check, sampled mid-cycle so the strobe is stable
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (done === 1'b1) begin
        if (expected_columns.size() == 0) begin
          flag_failure($sformatf("unexpected result %h", substituted_word));
        end else begin
          if (substituted_word !== expected_columns[0]) begin
            flag_failure($sformatf("substituted_word expected %h got %h",
                                   expected_columns[0], substituted_word));
          end
          void'(expected_columns.pop_front());
        end
      end else if (done !== 1'b0) begin
        flag_failure("done_o is unknown");
      end
    end
  end

  // Present one item; it is taken at the first edge with busy low
  task automatic send_column(word_t w);
    logic was_busy;
    start       <= 1'b1;
    column_word <= w;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy !== 1'b0);
    expected_columns.push_back(substitute_column(w));
  endtask

  // Sender gap; data toggles while start is low and must be ignored
  task automatic hold_off(int unsigned cycles);
    if (cycles != 0) begin
      start       <= 1'b0;
      column_word <= $urandom;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Stop sending until every expected result is back, with a limit
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (expected_columns.size() != 0 && waited < DrainCycles);
    if (expected_columns.size() != 0) begin
      flag_failure($sformatf("%0d results never arrived", expected_columns.size()));
      expected_columns.delete();
    end
  endtask

  task automatic test_corner_columns();
    foreach (CornerColumns[i]) send_column(CornerColumns[i]);
    wait_for_results();
  endtask

  // Random columns in bursts; some carry a zero byte in a random lane
  task automatic test_random_columns(int unsigned total);
    int unsigned sent;
    int unsigned burst;
    word_t       w;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 32);
      for (int k = 0; k < burst && sent < total; k++) begin
        w = $urandom;
        if ($urandom_range(0, 7) == 0) w[$urandom_range(0, NBytes-1)*ByteW +: ByteW] = '0;
        send_column(w);
        sent++;
      end
      hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
  endtask

  // Full pause mid-stream, then restart from an empty pipeline
  task automatic test_restart_after_empty();
    repeat (16) send_column($urandom);
    wait_for_results();
    repeat (16) send_column($urandom);
    wait_for_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_columns();
    test_random_columns(330);
    test_restart_after_empty();
    test_random_columns(330);
    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> aes_sub_bytes_word_unit.f
rtl/core/aes_sbw_pkg.sv
rtl/core/aes_sbw_lane.sv
rtl/core/aes_sub_bytes_word_unit.sv
tb/tb_top.sv
